### rtl/core/tnil_pkg.sv
package tnil_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam int FIELD_W = 31;
    localparam int SIZE_W  = 5;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [FIELD_W-1:0] score;
        logic [FIELD_W-1:0] item_key;
    } in_item_t;

    typedef struct packed {
        logic               out_valid;
        logic [FIELD_W-1:0] out_score;
        logic [FIELD_W-1:0] out_key;
        logic               out_last;
    } out_item_t;

    typedef struct packed {
        logic insert;
        logic clear;
        logic read_start;
        logic rotate;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic head_occupied;
        logic out_free;
        logic step_first;
        logic step_final;
    } dp_status_t;

endpackage

### rtl/core/tnil_ctrl.sv
module tnil_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [1:0]          item_cmd,
    input  tnil_pkg::dp_status_t status,
    output tnil_pkg::dp_cmd_t   cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;
    logic emit;
    logic go;

    assign item_stall = (state_reg == ST_READ);
    assign accept     = item_valid && !item_stall;

    // a step emits when the head entry is occupied, or on the first step of an empty list
    assign emit = status.head_occupied || status.step_first;
    assign go   = !emit || status.out_free;

    always_comb
    begin
        state_next     = state_reg;
        cmd.insert     = 1'b0;
        cmd.clear      = 1'b0;
        cmd.read_start = 1'b0;
        cmd.rotate     = 1'b0;
        cmd.load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item_cmd)
                        tnil_pkg::CMD_INSERT: cmd.insert = 1'b1;
                        tnil_pkg::CMD_CLEAR:  cmd.clear  = 1'b1;
                        tnil_pkg::CMD_READ:
                        begin
                            cmd.read_start = 1'b1;
                            state_next     = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                if (go)
                begin
                    cmd.rotate   = 1'b1;
                    cmd.load_out = emit;
                    if (status.step_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/tnil_datapath.sv
module tnil_datapath
#(
    parameter int LIST_DEPTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tnil_pkg::in_item_t                   item,
    input  tnil_pkg::dp_cmd_t                    cmd,
    output tnil_pkg::dp_status_t                 status,
    input  logic                                 cfg_wr,
    input  logic [tnil_pkg::SIZE_W-1:0]          cfg_data,
    output logic [tnil_pkg::SIZE_W-1:0]          list_size,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output tnil_pkg::out_item_t                  result
);

    localparam int NW = $clog2(LIST_DEPTH + 1);
    localparam int KW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int FW = tnil_pkg::FIELD_W;

    function automatic logic [NW-1:0] eff_size(input logic [tnil_pkg::SIZE_W-1:0] ls);
        int v;
        v = int'(ls);
        if (v == 0)
            v = 1;
        if (v > LIST_DEPTH)
            v = LIST_DEPTH;
        return NW'(v);
    endfunction

    logic [FW-1:0]         score_reg [LIST_DEPTH];
    logic [FW-1:0]         score_next [LIST_DEPTH];
    logic [FW-1:0]         key_reg [LIST_DEPTH];
    logic [FW-1:0]         key_next [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] occ_reg;
    logic [LIST_DEPTH-1:0] occ_next;
    logic [LIST_DEPTH-1:0] cond;

    logic [tnil_pkg::SIZE_W-1:0] list_size_reg;
    logic [KW-1:0]               step_reg;
    logic [KW-1:0]               step_next;
    logic                        out_valid_reg;
    tnil_pkg::out_item_t         out_item_reg;

    logic [NW-1:0] n_eff;
    logic [NW-1:0] n_new;
    logic          occ1;

    assign n_eff     = eff_size(list_size_reg);
    assign n_new     = eff_size(cfg_data);
    assign list_size = list_size_reg;

    // occupied entries are descending and contiguous, so cond is monotone over positions
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            cond[i] = !occ_reg[i] || (item.score > score_reg[i]);
        end
    end

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic          prv_cond;
        logic [FW-1:0] prv_score;
        logic [FW-1:0] prv_key;
        logic          prv_occ;
        logic [FW-1:0] nxt_score;
        logic [FW-1:0] nxt_key;
        logic          nxt_occ;
        logic          in_use;
        logic          is_tail;

        if (i == 0)
        begin : g_first
            assign prv_cond  = 1'b0;
            assign prv_score = '0;
            assign prv_key   = '0;
            assign prv_occ   = 1'b0;
        end
        else
        begin : g_inner
            assign prv_cond  = cond[i-1];
            assign prv_score = score_reg[i-1];
            assign prv_key   = key_reg[i-1];
            assign prv_occ   = occ_reg[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_end
            assign nxt_score = score_reg[0];
            assign nxt_key   = key_reg[0];
            assign nxt_occ   = occ_reg[0];
        end
        else
        begin : g_mid
            assign nxt_score = score_reg[i+1];
            assign nxt_key   = key_reg[i+1];
            assign nxt_occ   = occ_reg[i+1];
        end

        assign in_use  = NW'(i) < n_eff;
        assign is_tail = NW'(i) == (n_eff - NW'(1));

        always_comb
        begin
            score_next[i] = score_reg[i];
            key_next[i]   = key_reg[i];
            occ_next[i]   = occ_reg[i];
            if (cmd.clear || (cfg_wr && !(NW'(i) < n_new)))
            begin
                score_next[i] = '0;
                key_next[i]   = '0;
                occ_next[i]   = 1'b0;
            end
            else if (cmd.insert && in_use && cond[i])
            begin
                if (prv_cond)
                begin
                    score_next[i] = prv_score;
                    key_next[i]   = prv_key;
                    occ_next[i]   = prv_occ;
                end
                else
                begin
                    score_next[i] = item.score;
                    key_next[i]   = item.item_key;
                    occ_next[i]   = 1'b1;
                end
            end
            else if (cmd.rotate && in_use)
            begin
                // read out rotates the used positions toward the head
                if (is_tail)
                begin
                    score_next[i] = score_reg[0];
                    key_next[i]   = key_reg[0];
                    occ_next[i]   = occ_reg[0];
                end
                else
                begin
                    score_next[i] = nxt_score;
                    key_next[i]   = nxt_key;
                    occ_next[i]   = nxt_occ;
                end
            end
        end
    end

    if (LIST_DEPTH > 1)
    begin : g_occ1
        assign occ1 = occ_reg[1];
    end
    else
    begin : g_occ1_none
        assign occ1 = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            score_reg[i] <= score_next[i];
            key_reg[i]   <= key_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_size_reg <= tnil_pkg::SIZE_W'(16);
        end
        else if (cfg_wr)
        begin
            list_size_reg <= cfg_data;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (cmd.read_start)
            step_next = '0;
        else if (cmd.rotate)
            step_next = step_reg + KW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign status.head_occupied = occ_reg[0];
    assign status.out_free      = !out_valid_reg || !result_stall;
    assign status.step_first    = (step_reg == '0);
    assign status.step_final    = ((NW'(step_reg) + NW'(1)) == n_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_item_reg.out_valid <= occ_reg[0];
            out_item_reg.out_score <= occ_reg[0] ? score_reg[0] : '0;
            out_item_reg.out_key   <= occ_reg[0] ? key_reg[0] : '0;
            out_item_reg.out_last  <= !occ_reg[0] || status.step_final || !occ1;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

### rtl/core/top_n_insertion_list_core.sv
// Insert and clear: a new transaction every cycle while no read is in progress.
// Read: the accept moves the controller into its read state, then the list rotates past the
// head one step per position of the effective list_size; a step that emits waits while the
// output register is held by result_stall, and each emitting step loads that register.
// Input is stalled during a read. Results leave through a one-entry output register.
// Reset (rst_n, asynchronous, active low) empties the list and sets list_size to 16.
module top_n_insertion_list_core
#(
    parameter int LIST_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  tnil_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output tnil_pkg::out_item_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    tnil_pkg::dp_cmd_t           cmd;
    tnil_pkg::dp_status_t        status;
    logic                        cfg_wr;
    logic [tnil_pkg::SIZE_W-1:0] list_size;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - tnil_pkg::SIZE_W){1'b0}}, list_size} : 32'd0;

    tnil_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_cmd   (item.cmd),
        .status     (status),
        .cmd        (cmd)
    );

    tnil_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr       (cfg_wr),
        .cfg_data     (pwdata[tnil_pkg::SIZE_W-1:0]),
        .list_size    (list_size),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### dv/top_n_insertion_list_core_tb.sv
module top_n_insertion_list_core_tb;

    localparam int          DEPTH          = 16;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam logic [2:0]  LIST_SIZE_ADDR = 3'd0;
    localparam logic [2:0]  UNMAPPED_ADDR  = 3'd4;
    localparam logic [30:0] SCORE_MAX      = 31'h7FFF_FFFF;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    tnil_pkg::in_item_t  item;
    logic                result_valid;
    logic                result_stall;
    tnil_pkg::out_item_t result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // predicted ranking
    logic [30:0]         rank_score [DEPTH];
    logic [30:0]         rank_key [DEPTH];
    logic                rank_used [DEPTH];
    logic [4:0]          size_reg;
    tnil_pkg::out_item_t expected_ranks [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_left;
    int cycle_count;
    int mismatch_count;
    int sent_count;
    int read_count;
    int checked_count;

    top_n_insertion_list_core #(.LIST_DEPTH(DEPTH)) DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_ranks.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: long hold-off when requested, else random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    function automatic int effective_size();
        if (size_reg == 5'd0)
            return 1;
        if (size_reg > DEPTH)
            return DEPTH;
        return size_reg;
    endfunction

    task automatic empty_ranks_from(input int start);
        for (int j = start; j < DEPTH; j++)
        begin
            rank_score[j] = '0;
            rank_key[j]   = '0;
            rank_used[j]  = 1'b0;
        end
    endtask

    task automatic resize_ranking(input logic [4:0] value);
        size_reg = value;
        empty_ranks_from(effective_size());
    endtask

    task automatic update_ranking(input tnil_pkg::in_item_t t);
        int                  n;
        int                  pos;
        int                  cnt;
        tnil_pkg::out_item_t r;
        n = effective_size();
        case (t.cmd)
            tnil_pkg::CMD_INSERT:
            begin
                pos = 0;
                while (pos < n && rank_used[pos] && t.score <= rank_score[pos])
                    pos++;
                if (pos < n)
                begin
                    for (int j = n - 1; j > pos; j--)
                    begin
                        rank_score[j] = rank_score[j-1];
                        rank_key[j]   = rank_key[j-1];
                        rank_used[j]  = rank_used[j-1];
                    end
                    rank_score[pos] = t.score;
                    rank_key[pos]   = t.item_key;
                    rank_used[pos]  = 1'b1;
                end
            end
            tnil_pkg::CMD_CLEAR:
            begin
                empty_ranks_from(0);
            end
            tnil_pkg::CMD_READ:
            begin
                read_count++;
                cnt = 0;
                while (cnt < n && rank_used[cnt])
                    cnt++;
                if (cnt == 0)
                begin
                    r          = '0;
                    r.out_last = 1'b1;
                    expected_ranks.push_back(r);
                end
                for (int k = 0; k < cnt; k++)
                begin
                    r.out_valid = 1'b1;
                    r.out_score = rank_score[k];
                    r.out_key   = rank_key[k];
                    r.out_last  = (k + 1 == cnt);
                    expected_ranks.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge clk)
    begin
        tnil_pkg::out_item_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            checked_count++;
            if (expected_ranks.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result v%0b s%0d k%0d l%0b",
                              result.out_valid, result.out_score,
                              result.out_key, result.out_last));
            end
            else
            begin
                exp_r = expected_ranks.pop_front();
                if (result.out_valid !== exp_r.out_valid
                    || result.out_score !== exp_r.out_score
                    || result.out_key !== exp_r.out_key
                    || result.out_last !== exp_r.out_last)
                begin
                    note_mismatch($sformatf(
                        "exp v%0b s%0d k%0d l%0b, got v%0b s%0d k%0d l%0b",
                        exp_r.out_valid, exp_r.out_score, exp_r.out_key,
                        exp_r.out_last, result.out_valid, result.out_score,
                        result.out_key, result.out_last));
                end
            end
        end
    end

    function automatic tnil_pkg::in_item_t make_item(input logic [1:0] cmd,
                                                     input logic [30:0] sc,
                                                     input logic [30:0] key);
        tnil_pkg::in_item_t t;
        t.cmd      = cmd;
        t.score    = sc;
        t.item_key = key;
        return t;
    endfunction

    // valid stays high across back-to-back transactions
    task automatic send_item(input tnil_pkg::in_item_t t);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= t;
        do
            @(posedge clk);
        while (item_stall);
        sent_count++;
        update_ranking(t);
    endtask

    task automatic wait_for_quiet();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_ranks.size() != 0 || item_stall)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == LIST_SIZE_ADDR)
            resize_ranking(value[4:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_list_size(input logic [31:0] value);
        wait_for_quiet();
        write_register(LIST_SIZE_ADDR, value);
    endtask

    function automatic logic [30:0] random_score();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 31'($urandom_range(15));
        if (roll < 90)
            return 31'($urandom & SCORE_MAX);
        return roll[0] ? SCORE_MAX : 31'd0;
    endfunction

    function automatic tnil_pkg::in_item_t random_item();
        int          roll;
        logic [1:0]  cmd;
        roll = $urandom_range(99);
        if (roll < 70)
            cmd = tnil_pkg::CMD_INSERT;
        else if (roll < 90)
            cmd = tnil_pkg::CMD_READ;
        else if (roll < 94)
            cmd = tnil_pkg::CMD_CLEAR;
        else
            cmd = CMD_UNUSED;
        return make_item(cmd, random_score(), 31'($urandom & SCORE_MAX));
    endfunction

    task automatic test_directed();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
        send_item(make_item(tnil_pkg::CMD_INSERT, SCORE_MAX, 31'd0));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd0, SCORE_MAX));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd100, 31'd1));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd100, 31'd2));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd100, 31'd3));
        send_item(make_item(CMD_UNUSED, 31'd55, 31'd55));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'h4000_0000, 31'h2AAA_AAAA));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd1, 31'h5555_5555));
        send_item(make_item(tnil_pkg::CMD_READ, SCORE_MAX, SCORE_MAX));
        send_item(make_item(tnil_pkg::CMD_CLEAR, 31'd9, 31'd9));
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd7, 31'd7));
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
    endtask

    task automatic test_list_sizes();
        set_list_size(32'd1);
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd5, 31'd1));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd5, 31'd2));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd9, 31'd3));
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
        set_list_size(32'd0);
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd10, 31'd4));
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
        set_list_size(32'd31);
        for (int i = 0; i < 18; i++)
            send_item(make_item(tnil_pkg::CMD_INSERT, 31'($urandom_range(20, 1)), 31'(i)));
        send_item(make_item(tnil_pkg::CMD_INSERT, 31'd0, 31'd77));
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
        // upper data bits are don't-care
        set_list_size(32'hFFFF_FFE4);
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
        wait_for_quiet();
        write_register(UNMAPPED_ADDR, 32'd1);
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
        set_list_size(32'd17);
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
        set_list_size(32'd16);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [31:0] size_value, input int count);
        set_list_size(size_value);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_item(random_item());
        send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
    endtask

    task automatic test_hold_off();
        set_list_size(32'd16);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        @(posedge clk);
        hold_left = 300;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 6 == 5)
                send_item(make_item(tnil_pkg::CMD_READ, 31'd0, 31'd0));
            else
                send_item(make_item(tnil_pkg::CMD_INSERT, random_score(),
                                    31'($urandom & SCORE_MAX)));
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        item_valid         = 1'b0;
        item               = '0;
        result_stall       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        hold_left          = 0;
        cycle_count        = 0;
        mismatch_count     = 0;
        sent_count         = 0;
        read_count         = 0;
        checked_count      = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        size_reg           = 5'd16;
        empty_ranks_from(0);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_list_sizes();
        test_random_phase(0, 0, 32'd16, 40);
        test_random_phase(53, 0, $urandom_range(16, 1), 40);
        test_random_phase(0, 53, $urandom_range(31), 40);
        test_random_phase(20, 20, $urandom_range(8, 1), 40);
        test_hold_off();

        wait_for_quiet();
        repeat (20) @(posedge clk);
        $display("%0d transactions sent (%0d reads), %0d results checked, %0d mismatches",
                 sent_count, read_count, checked_count, mismatch_count);
        $display("list sizes 0..31 with saturation, ties, drops, clears, long output hold-off");
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/tnil_pkg.sv
rtl/core/tnil_ctrl.sv
rtl/core/tnil_datapath.sv
rtl/core/top_n_insertion_list_core.sv
dv/top_n_insertion_list_core_tb.sv
